>>> sv/tak_pkg.sv
// ----------------------------------------------------------------------------
// tak_pkg
// shared types and constants of the tilt angle kalman filter unit
// ----------------------------------------------------------------------------
package tak_pkg;

  localparam int unsigned FracBits  = 28;
  localparam int unsigned OpWidth   = 34;   // multiplier operand width
  localparam int unsigned DataWidth = 32;   // state and result width
  localparam int unsigned CfgWidth  = 31;   // widest configuration register

  // register indexes of the configuration port
  localparam logic [1:0] CfgAngleNoise = 2'd0;
  localparam logic [1:0] CfgBiasNoise  = 2'd1;
  localparam logic [1:0] CfgMeasNoise  = 2'd2;
  localparam logic [1:0] CfgStepTime   = 2'd3;

  localparam logic signed [OpWidth-1:0]   OneQ428Op = 34'sd268435456;
  localparam logic signed [DataWidth-1:0] OneQ428   = 32'sd268435456;

  // one request to the shared multiply-accumulate unit:
  // result = sat32(addend +/- ((op_a * op_b) >>> 28))
  typedef struct packed {
    logic signed [OpWidth-1:0]   op_a;
    logic signed [OpWidth-1:0]   op_b;
    logic signed [DataWidth-1:0] addend;
    logic                        sub;
  } mac_req_t;

endpackage

>>> sv/tak_mac.sv
// ----------------------------------------------------------------------------
// tak_mac
// shared q4.28 multiply and saturating accumulate, product registered
// ----------------------------------------------------------------------------
module tak_mac (
  input  logic                            clk_i,
  input  tak_pkg::mac_req_t               req_i,
  output logic signed [tak_pkg::DataWidth-1:0] res_o
);
  import tak_pkg::*;

  localparam int unsigned ProdWidth = 2 * OpWidth;
  localparam int unsigned RedWidth  = ProdWidth - FracBits;
  localparam int unsigned SumWidth  = RedWidth + 1;

  logic signed [ProdWidth-1:0] full_prod;
  logic signed [RedWidth-1:0]  prod_q;
  logic signed [DataWidth-1:0] addend_q;
  logic                        sub_q;
  logic signed [SumWidth-1:0]  sum;

  assign full_prod = req_i.op_a * req_i.op_b;

  // dropping the low bits of a two's complement product is the floor shift
  always_ff @(posedge clk_i) begin
    prod_q   <= full_prod[ProdWidth-1:FracBits];
    addend_q <= req_i.addend;
    sub_q    <= req_i.sub;
  end

  always_comb begin
    if (sub_q) begin
      sum = SumWidth'(addend_q) - SumWidth'(prod_q);
    end else begin
      sum = SumWidth'(addend_q) + SumWidth'(prod_q);
    end
    if (sum > SumWidth'(32'sh7fff_ffff)) begin
      res_o = 32'sh7fff_ffff;
    end else if (sum < SumWidth'(32'sh8000_0000)) begin
      res_o = 32'sh8000_0000;
    end else begin
      res_o = sum[DataWidth-1:0];
    end
  end

endmodule

>>> sv/tak_div.sv
// ----------------------------------------------------------------------------
// tak_div
// gain divider: sat32((num << 28) / den), truncated toward zero, one bit a cycle
// ----------------------------------------------------------------------------
module tak_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [tak_pkg::DataWidth-1:0] num_i,
  input  logic signed [tak_pkg::DataWidth:0]   den_i,
  output logic                                 done_o,
  output logic signed [tak_pkg::DataWidth-1:0] quot_o
);
  import tak_pkg::*;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } div_state_e;

  div_state_e                  state_q;
  logic                        done_q;
  logic                        neg_q;
  logic [4:0]                  cnt_q;
  logic [DataWidth:0]          dmag_q;
  logic [DataWidth:0]          rem_q;
  logic [DataWidth-1:0]        low_q;
  logic signed [DataWidth-1:0] quot_q;

  logic signed [DataWidth:0]   num_ext;
  logic signed [DataWidth:0]   num_abs;
  logic signed [DataWidth+1:0] den_ext;
  logic signed [DataWidth+1:0] den_abs;
  logic [DataWidth-1:0]        mag_n;
  logic [DataWidth:0]          mag_e;
  logic [DataWidth:0]          hi_n;
  logic [DataWidth+1:0]        rem2;
  logic [DataWidth+1:0]        rem_nx;
  logic                        ge;

  always_comb begin
    num_ext = {num_i[DataWidth-1], num_i};
    num_abs = num_ext[DataWidth] ? -num_ext : num_ext;
    mag_n   = num_abs[DataWidth-1:0];
    den_ext = {den_i[DataWidth], den_i};
    den_abs = den_ext[DataWidth+1] ? -den_ext : den_ext;
    mag_e   = den_abs[DataWidth:0];
    // upper part of the magnitude of num << 28
    hi_n    = {5'b0, mag_n[DataWidth-1:4]};
    rem2    = {rem_q, low_q[DataWidth-1]};
    ge      = rem2 >= {1'b0, dmag_q};
    // stays below the divisor, so the top bit is always zero
    rem_nx  = ge ? (rem2 - {1'b0, dmag_q}) : rem2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            neg_q  <= num_i[DataWidth-1] ^ den_i[DataWidth];
            dmag_q <= mag_e;
            rem_q  <= hi_n;
            low_q  <= {mag_n[3:0], 28'b0};
            cnt_q  <= '0;
            if (den_i == '0) begin
              quot_q <= '0;
              done_q <= 1'b1;
            end else if (hi_n >= mag_e) begin
              // quotient magnitude reaches 2^32
              quot_q <= (num_i[DataWidth-1] ^ den_i[DataWidth]) ?
                        32'sh8000_0000 : 32'sh7fff_ffff;
              done_q <= 1'b1;
            end else begin
              state_q <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_q <= rem_nx[DataWidth:0];
          low_q <= {low_q[DataWidth-2:0], ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          if (!neg_q) begin
            quot_q <= low_q[DataWidth-1] ? 32'sh7fff_ffff : $signed(low_q);
          end else begin
            quot_q <= (low_q > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(low_q);
          end
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> sv/tilt_angle_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter_unit
// two-state angle and gyro bias kalman filter for one tilt axis
// ----------------------------------------------------------------------------
// input channel (in_valid_i / in_ready_o) carries one sample: accelerometer
// angle and gyro rate, both q16.16. output channel (out_valid_o /
// out_ready_i) returns the fused angle and the bias-corrected rate.
// the configuration port writes the noise terms and the sample period
// (q4.28) with cfg_we_i, cfg_idx_i and cfg_data_i; write only while idle.
// one sample runs through thirteen multiply-accumulate steps (S_MUL, then
// S_WB) on the shared multiplier, two gain divisions on the bit-serial
// divider and one load of the output register. a gain that saturates
// early or a zero divisor ends its division without the bit-serial run.
// in_ready_o is high only while the sequencer is idle, so at most one
// sample is in flight; the result sits in an output register, so a new
// sample can be taken while the previous result waits for out_ready_i.
// if the receiver still holds the previous result when the next one is
// done, the sequencer waits without touching the output register.
// reset loads the register defaults, zero estimates and unit covariance.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [24:0]                 measured_angle_i,
  input  logic signed [27:0]                 gyro_rate_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [31:0]                 fused_angle_o,
  output logic signed [31:0]                 corrected_rate_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [tak_pkg::CfgWidth-1:0]       cfg_data_i
);
  import tak_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WB,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } seq_state_e;

  typedef enum logic [3:0] {
    OP_ANGLE_PRED,
    OP_CAA_PRED,
    OP_CAB_PRED,
    OP_CBA_PRED,
    OP_CBB_PRED,
    OP_CBA_UPD,
    OP_CBB_UPD,
    OP_CAA_UPD,
    OP_CAB_UPD,
    OP_ERR,
    OP_ANGLE_UPD,
    OP_BIAS_UPD,
    OP_RATE
  } op_e;

  seq_state_e state_q;
  op_e        op_q;
  logic       div_sel_q;
  logic       div_start;

  logic [28:0] qa_q;
  logic [28:0] qg_q;
  logic [30:0] r_q;
  logic [28:0] dt_q;

  logic signed [24:0] meas_q;
  logic signed [27:0] gyro_q;

  logic signed [DataWidth-1:0] angle_q;
  logic signed [DataWidth-1:0] bias_q;
  logic signed [DataWidth-1:0] caa_q;
  logic signed [DataWidth-1:0] cab_q;
  logic signed [DataWidth-1:0] cba_q;
  logic signed [DataWidth-1:0] cbb_q;
  logic signed [DataWidth-1:0] k0_q;
  logic signed [DataWidth-1:0] k1_q;
  logic signed [DataWidth-1:0] tmp_q;   // innovation, then corrected rate

  logic                        out_valid_q;
  logic signed [DataWidth-1:0] fused_q;
  logic signed [DataWidth-1:0] rate_q;

  mac_req_t                    mac_req;
  logic signed [DataWidth-1:0] mac_res;
  logic signed [DataWidth:0]   div_den;
  logic signed [DataWidth-1:0] div_num;
  logic                        div_done;
  logic signed [DataWidth-1:0] div_quot;

  logic signed [OpWidth-1:0] dt_op;

  assign dt_op   = $signed({5'b0, dt_q});
  assign div_den = $signed({2'b0, r_q}) + $signed({caa_q[DataWidth-1], caa_q});
  assign div_num = div_sel_q ? cba_q : caa_q;
  assign div_start = (state_q == S_DIV_GO);

  always_comb begin
    mac_req.op_a   = OpWidth'(angle_q);
    mac_req.op_b   = OneQ428Op;
    mac_req.addend = DataWidth'(meas_q);
    mac_req.sub    = 1'b1;
    case (op_q)
      OP_ANGLE_PRED: begin
        mac_req.op_a   = OpWidth'(gyro_q) - OpWidth'(bias_q);
        mac_req.op_b   = dt_op;
        mac_req.addend = angle_q;
        mac_req.sub    = 1'b0;
      end
      OP_CAA_PRED: begin
        mac_req.op_a   = $signed({5'b0, qa_q}) - OpWidth'(cab_q) - OpWidth'(cba_q);
        mac_req.op_b   = dt_op;
        mac_req.addend = caa_q;
        mac_req.sub    = 1'b0;
      end
      OP_CAB_PRED: begin
        mac_req.op_a   = OpWidth'(cbb_q);
        mac_req.op_b   = dt_op;
        mac_req.addend = cab_q;
        mac_req.sub    = 1'b1;
      end
      OP_CBA_PRED: begin
        mac_req.op_a   = OpWidth'(cbb_q);
        mac_req.op_b   = dt_op;
        mac_req.addend = cba_q;
        mac_req.sub    = 1'b1;
      end
      OP_CBB_PRED: begin
        mac_req.op_a   = $signed({5'b0, qg_q});
        mac_req.op_b   = dt_op;
        mac_req.addend = cbb_q;
        mac_req.sub    = 1'b0;
      end
      // update order keeps the predicted caa and cab for every product
      OP_CBA_UPD: begin
        mac_req.op_a   = OpWidth'(k1_q);
        mac_req.op_b   = OpWidth'(caa_q);
        mac_req.addend = cba_q;
        mac_req.sub    = 1'b1;
      end
      OP_CBB_UPD: begin
        mac_req.op_a   = OpWidth'(k1_q);
        mac_req.op_b   = OpWidth'(cab_q);
        mac_req.addend = cbb_q;
        mac_req.sub    = 1'b1;
      end
      OP_CAA_UPD: begin
        mac_req.op_a   = OpWidth'(k0_q);
        mac_req.op_b   = OpWidth'(caa_q);
        mac_req.addend = caa_q;
        mac_req.sub    = 1'b1;
      end
      OP_CAB_UPD: begin
        mac_req.op_a   = OpWidth'(k0_q);
        mac_req.op_b   = OpWidth'(cab_q);
        mac_req.addend = cab_q;
        mac_req.sub    = 1'b1;
      end
      // times one in q4.28 gives a plain saturating subtract
      OP_ERR: begin
        mac_req.op_a   = OpWidth'(angle_q);
        mac_req.op_b   = OneQ428Op;
        mac_req.addend = DataWidth'(meas_q);
        mac_req.sub    = 1'b1;
      end
      OP_ANGLE_UPD: begin
        mac_req.op_a   = OpWidth'(k0_q);
        mac_req.op_b   = OpWidth'(tmp_q);
        mac_req.addend = angle_q;
        mac_req.sub    = 1'b0;
      end
      OP_BIAS_UPD: begin
        mac_req.op_a   = OpWidth'(k1_q);
        mac_req.op_b   = OpWidth'(tmp_q);
        mac_req.addend = bias_q;
        mac_req.sub    = 1'b0;
      end
      OP_RATE: begin
        mac_req.op_a   = OpWidth'(bias_q);
        mac_req.op_b   = OneQ428Op;
        mac_req.addend = DataWidth'(gyro_q);
        mac_req.sub    = 1'b1;
      end
      default: begin
        mac_req.op_a   = OpWidth'(angle_q);
        mac_req.op_b   = OneQ428Op;
        mac_req.addend = DataWidth'(meas_q);
        mac_req.sub    = 1'b1;
      end
    endcase
  end

  tak_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .res_o (mac_res)
  );

  tak_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q  <= 29'd268435;
      qg_q  <= 29'd805306;
      r_q   <= 31'd134217728;
      dt_q  <= 29'd5368709;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAngleNoise: qa_q <= cfg_data_i[28:0];
        CfgBiasNoise:  qg_q <= cfg_data_i[28:0];
        CfgMeasNoise:  r_q  <= cfg_data_i;
        CfgStepTime:   dt_q <= cfg_data_i[28:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ANGLE_PRED;
      div_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
      angle_q     <= '0;
      bias_q      <= '0;
      caa_q       <= OneQ428;
      cab_q       <= '0;
      cba_q       <= '0;
      cbb_q       <= OneQ428;
    end else begin
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            meas_q  <= measured_angle_i;
            gyro_q  <= gyro_rate_i;
            op_q    <= OP_ANGLE_PRED;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_WB;
        end
        S_WB: begin
          case (op_q)
            OP_ANGLE_PRED: angle_q <= mac_res;
            OP_CAA_PRED:   caa_q   <= mac_res;
            OP_CAB_PRED:   cab_q   <= mac_res;
            OP_CBA_PRED:   cba_q   <= mac_res;
            OP_CBB_PRED:   cbb_q   <= mac_res;
            OP_CBA_UPD:    cba_q   <= mac_res;
            OP_CBB_UPD:    cbb_q   <= mac_res;
            OP_CAA_UPD:    caa_q   <= mac_res;
            OP_CAB_UPD:    cab_q   <= mac_res;
            OP_ERR:        tmp_q   <= mac_res;
            OP_ANGLE_UPD:  angle_q <= mac_res;
            OP_BIAS_UPD:   bias_q  <= mac_res;
            OP_RATE:       tmp_q   <= mac_res;
            default: begin
            end
          endcase
          if (op_q == OP_RATE) begin
            op_q    <= OP_ANGLE_PRED;
            state_q <= S_OUT;
          end else if (op_q == OP_CBB_PRED) begin
            // prediction done, gains come next
            op_q      <= OP_CBA_UPD;
            div_sel_q <= 1'b0;
            state_q   <= S_DIV_GO;
          end else begin
            op_q    <= op_e'(op_q + 4'd1);
            state_q <= S_MUL;
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (!div_sel_q) begin
              k0_q      <= div_quot;
              div_sel_q <= 1'b1;
              state_q   <= S_DIV_GO;
            end else begin
              k1_q    <= div_quot;
              state_q <= S_MUL;
            end
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            fused_q <= angle_q;
            rate_q  <= tmp_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign fused_angle_o    = fused_q;
  assign corrected_rate_o = rate_q;

endmodule

>>> test/tilt_angle_kalman_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter_unit_tb
// self-checking bench of the tilt angle kalman filter unit. a directed table
// walks field extremes, the zero divisor, register masking and saturating
// runs. random phases follow, later ones with new noise and period settings.
// the fused angle and corrected rate of every transfer are checked against
// a bit-exact fixed point model of the filter or the values of a typed row.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tak_pkg::*;

  localparam int AngleLimit = 11796480;   // 180 degrees, q16.16
  localparam int RateLimit  = 131072000;  // 2000 degrees per second, q16.16
  localparam int NumPhases  = 12;
  localparam int PhaseItems = 148;
  localparam int NumRows    = 40;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    logic [1:0]                  idx;       // register index of a write row
    logic [CfgWidth-1:0]         data;
    logic signed [24:0]          meas;
    logic signed [27:0]          gyro;
    bit                          typed;     // expected result given in the row
    logic signed [DataWidth-1:0] exp_angle;
    logic signed [DataWidth-1:0] exp_rate;
  } stim_row_t;

  typedef struct {
    logic signed [DataWidth-1:0] fused;
    logic signed [DataWidth-1:0] rate;
  } angle_rate_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic signed [24:0]          measured_angle_i;
  logic signed [27:0]          gyro_rate_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [31:0]          fused_angle_o;
  logic signed [31:0]          corrected_rate_o;
  logic                        cfg_we_i;
  logic [1:0]                  cfg_idx_i;
  logic [CfgWidth-1:0]         cfg_data_i;

  tilt_angle_kalman_filter_unit dut (.*);

  // filter model: settings and state
  longint noise_angle, noise_bias, noise_meas, sample_dt;
  int     est_angle, est_bias, cov_aa, cov_ab, cov_ba, cov_bb;

  angle_rate_t pending_results_q[$];
  int          mismatch_count;
  int          in_stall_pct;
  int          out_stall_pct;
  int          trk_true, trk_rate, trk_offset;

  stim_row_t directed_rows [NumRows] = '{
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd0, 28'sd0, 1'b1, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd11796480, 28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, -25'sd11796480, -28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sh0FFFFFF, 28'sh7FFFFFF, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sh1000000, 28'sh8000000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, -25'sd1, 28'sd1, 1'b0, 32'sd0, 32'sd0},
    // no process noise, no measurement noise, period masked down to zero
    '{RowWrite, CfgAngleNoise, 31'd0, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgBiasNoise, 31'd0, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgMeasNoise, 31'd0, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgStepTime, 31'h2000_0000, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    // unit gain empties the angle covariance, then the divisor is zero
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd65536, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, -25'sd65536, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd0, 28'sd65536, 1'b0, 32'sd0, 32'sd0},
    // all-ones writes, masked to the register widths, then a unit bias noise
    '{RowWrite, CfgStepTime, 31'h7FFF_FFFF, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgMeasNoise, 31'h7FFF_FFFF, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgAngleNoise, 31'h7FFF_FFFF, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgBiasNoise, 31'd268435456, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    // full rate runs drive the estimate and the innovation into saturation
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd11796480, 28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd11796480, 28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd11796480, 28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd11796480, 28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd11796480, 28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd11796480, 28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd11796480, 28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd11796480, 28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, -25'sd11796480, -28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, -25'sd11796480, -28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, -25'sd11796480, -28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, -25'sd11796480, -28'sd131072000, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgMeasNoise, 31'd1, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgStepTime, 31'd1, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgAngleNoise, 31'd268435456, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgBiasNoise, 31'd0, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd5000, -28'sd70000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, -25'sd300000, 28'sd9000000, 1'b0, 32'sd0, 32'sd0},
    '{RowSample, CfgAngleNoise, 31'd0, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    // back to the reset defaults
    '{RowWrite, CfgAngleNoise, 31'd268435, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgBiasNoise, 31'd805306, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgMeasNoise, 31'd134217728, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{RowWrite, CfgStepTime, 31'd5368709, 25'sd0, 28'sd0, 1'b0, 32'sd0, 32'sd0}
  };

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int sat32(longint x);
    if (x > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (x < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
    return int'(x);
  endfunction

  // q4.28 product, floored by the arithmetic shift
  function automatic longint mul_q28(longint a, longint b);
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    pa = 128'(a);
    pb = 128'(b);
    pa = (pa * pb) >>> FracBits;
    return longint'(pa);
  endfunction

  // one filter step: predict, gains, covariance update, correction
  function automatic angle_rate_t predict_fused_angle(logic signed [24:0] meas_f,
                                                      logic signed [27:0] gyro_f);
    longint      meas, gyro, d0, pct0, pct1, t1, e, k0, k1, err;
    int          k0s, k1s;
    angle_rate_t res;
    meas = longint'(meas_f);
    gyro = longint'(gyro_f);
    est_angle = sat32(est_angle + mul_q28(gyro - est_bias, sample_dt));

    d0     = noise_angle - cov_ab - cov_ba;
    cov_aa = sat32(cov_aa + mul_q28(d0, sample_dt));
    cov_ab = sat32(cov_ab - mul_q28(longint'(cov_bb), sample_dt));
    cov_ba = sat32(cov_ba - mul_q28(longint'(cov_bb), sample_dt));
    cov_bb = sat32(cov_bb + mul_q28(noise_bias, sample_dt));

    pct0 = longint'(cov_aa);
    pct1 = longint'(cov_ba);
    e    = noise_meas + pct0;
    k0   = 0;
    k1   = 0;
    if (e != 0) begin
      k0 = (pct0 * longint'(OneQ428)) / e;
      k1 = (pct1 * longint'(OneQ428)) / e;
    end
    k0s = sat32(k0);
    k1s = sat32(k1);

    t1     = longint'(cov_ab);
    cov_aa = sat32(cov_aa - mul_q28(longint'(k0s), pct0));
    cov_ab = sat32(cov_ab - mul_q28(longint'(k0s), t1));
    cov_ba = sat32(cov_ba - mul_q28(longint'(k1s), pct0));
    cov_bb = sat32(cov_bb - mul_q28(longint'(k1s), t1));

    err       = longint'(sat32(meas - est_angle));
    est_angle = sat32(est_angle + mul_q28(longint'(k0s), err));
    est_bias  = sat32(est_bias + mul_q28(longint'(k1s), err));

    res.fused = est_angle;
    res.rate  = sat32(gyro - est_bias);
    return res;
  endfunction

  function automatic int clamp_int(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // extremes, raw all-width values, or log-spread typical values
  function automatic logic [CfgWidth-1:0] draw_reg_value(logic [1:0] idx);
    int unsigned width, lo, hi, span, v;
    case (idx)
      CfgAngleNoise: begin width = 29; lo = 0; hi = 32'd268435456; end
      CfgBiasNoise:  begin width = 29; lo = 0; hi = 32'd268435456; end
      CfgMeasNoise:  begin width = 31; lo = 1; hi = 32'd2147483647; end
      default:       begin width = 29; lo = 1; hi = 32'd268435456; end
    endcase
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CfgWidth'(lo);
      2: return CfgWidth'(hi);
      3: return CfgWidth'((32'd1 << width) - 1);
      4: return CfgWidth'($urandom);
      default: begin
        span = 32'd1 << $urandom_range(4, width - 2);
        v = lo + $urandom_range(0, span);
        return CfgWidth'((v > hi) ? hi : v);
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CfgWidth-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgAngleNoise: noise_angle = longint'(data[28:0]);
      CfgBiasNoise:  noise_bias  = longint'(data[28:0]);
      CfgMeasNoise:  noise_meas  = longint'(data[30:0]);
      CfgStepTime:   sample_dt   = longint'(data[28:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // holds the sample until its transfer, then books the expected result
  task automatic send_sample(logic signed [24:0] meas, logic signed [27:0] gyro,
                             bit typed, logic signed [31:0] exp_angle,
                             logic signed [31:0] exp_rate);
    angle_rate_t want;
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    measured_angle_i <= meas;
    gyro_rate_i      <= gyro;
    do @(posedge clk_i); while (!in_ready_o);
    want = predict_fused_angle(meas, gyro);
    if (typed) begin
      want.fused = exp_angle;
      want.rate  = exp_rate;
    end
    pending_results_q.push_back(want);
  endtask

  task automatic sender_pause();
    int gap;
    if ($urandom_range(0, 99) < in_stall_pct) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: ready drops in random bursts
  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && $urandom_range(0, 99) < out_stall_pct) hold = $urandom_range(1, 11);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    angle_rate_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: angle %0d rate %0d",
                                  fused_angle_o, corrected_rate_o));
      end else begin
        want = pending_results_q.pop_front();
        if (fused_angle_o !== want.fused)
          report_mismatch($sformatf("fused_angle %0d, model %0d", fused_angle_o, want.fused));
        if (corrected_rate_o !== want.rate)
          report_mismatch($sformatf("corrected_rate %0d, model %0d",
                                    corrected_rate_o, want.rate));
      end
    end
  end

  initial begin
    #20ms;
    $display("[tilt_angle_kalman_filter_unit] ERROR");
    $finish;
  end

  initial begin
    int                 sel;
    int                 meas_v, gyro_v;
    logic signed [24:0] meas;
    logic signed [27:0] gyro;
    int                 stall_choice [4] = '{0, 8, 30, 60};

    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    measured_angle_i = '0;
    gyro_rate_i      = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CfgAngleNoise;
    cfg_data_i       = '0;
    mismatch_count   = 0;
    in_stall_pct     = 20;
    out_stall_pct    = 20;
    noise_angle      = 268435;
    noise_bias       = 805306;
    noise_meas       = 134217728;
    sample_dt        = 5368709;
    est_angle        = 0;
    est_bias         = 0;
    cov_aa           = OneQ428;
    cov_ab           = 0;
    cov_ba           = 0;
    cov_bb           = OneQ428;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowWrite) begin
        wait_results_done();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].meas, directed_rows[i].gyro, directed_rows[i].typed,
                    directed_rows[i].exp_angle, directed_rows[i].exp_rate);
        sender_pause();
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_results_done();
      // first phase keeps the defaults, the others draw new settings
      if (ph > 0) begin
        for (int r = 0; r < 4; r++) write_reg(r[1:0], draw_reg_value(r[1:0]));
      end
      if (ph == NumPhases - 1) begin
        in_stall_pct  = 0;
        out_stall_pct = 0;
      end else begin
        in_stall_pct  = stall_choice[$urandom_range(0, 3)];
        out_stall_pct = stall_choice[$urandom_range(0, 3)];
      end
      trk_true   = int'($urandom_range(0, 2 * AngleLimit)) - AngleLimit;
      trk_rate   = 0;
      trk_offset = int'($urandom_range(0, 655360)) - 327680;

      for (int n = 0; n < PhaseItems; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          // a plausible motion: drifting rate, noisy angle, offset gyro
          trk_rate = clamp_int(trk_rate + int'($urandom_range(0, 2621440)) - 1310720,
                               32768000);
          trk_true = trk_true + trk_rate / 64;
          if (trk_true > AngleLimit || trk_true < -AngleLimit) begin
            trk_true = clamp_int(trk_true, AngleLimit);
            trk_rate = -trk_rate;
          end
          meas_v = clamp_int(trk_true + int'($urandom_range(0, 262144)) - 131072,
                             AngleLimit);
          gyro_v = clamp_int(trk_rate + trk_offset + int'($urandom_range(0, 65536)) - 32768,
                             RateLimit);
          meas = 25'(meas_v);
          gyro = 28'(gyro_v);
        end else if (sel < 88) begin
          meas = 25'(int'($urandom_range(0, 2 * AngleLimit)) - AngleLimit);
          gyro = 28'(int'($urandom_range(0, 2 * RateLimit)) - RateLimit);
        end else begin
          meas = 25'($urandom);
          gyro = 28'($urandom);
        end
        send_sample(meas, gyro, 1'b0, '0, '0);
        sender_pause();
      end
    end

    wait_results_done();
    repeat (150) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results_q.size() == 0) begin
      $display("[tilt_angle_kalman_filter_unit] OK");
    end else begin
      $display("[tilt_angle_kalman_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
